@@ design/jtg_pkg.sv @@
package jtg_pkg;

  // fixed-point scale of the sine table
  localparam int SINE_FRAC_BITS = 15;
  localparam int SINE_W         = SINE_FRAC_BITS + 1;
  localparam int SV_W           = SINE_W + 1;
  localparam int PROD_W         = 16 + SV_W;
  localparam int NUM_W          = PROD_W + 2;

  // quarter-wave table, phase counts 4000 units per turn
  localparam int TAB_LAST = 1000;
  localparam int IDX_W    = $clog2(TAB_LAST + 1);
  localparam int PHASE_W  = 12;
  localparam int LOOK_W   = PHASE_W + 1;

  localparam logic [PHASE_W-1:0] PHASE_HALF       = PHASE_W'(2000);
  localparam logic [PHASE_W-1:0] PHASE_TURN       = PHASE_W'(4000);
  localparam logic [PHASE_W-1:0] PHASE_MAX        = PHASE_W'(4003);
  localparam logic [PHASE_W-1:0] PHASE_STEP_POINT = PHASE_W'(2);
  localparam logic [PHASE_W-1:0] PHASE_STEP_FAST  = PHASE_W'(4);
  localparam logic [PHASE_W-1:0] PHASE_STEP_SLOW  = PHASE_W'(1);

  localparam logic [LOOK_W-1:0] LOOK_QUARTER = LOOK_W'(1000);
  localparam logic [LOOK_W-1:0] LOOK_HALF    = LOOK_W'(2000);
  localparam logic [LOOK_W-1:0] LOOK_3Q      = LOOK_W'(3000);
  localparam logic [LOOK_W-1:0] LOOK_TURN    = LOOK_W'(4000);

  localparam logic signed [15:0] AMP_FAST = 16'sd4096;
  localparam logic signed [15:0] AMP_SLOW = 16'sd8192;

  localparam logic signed [NUM_W-1:0] OFFS_FAST_NUM = NUM_W'(4096) <<< SINE_FRAC_BITS;
  localparam logic signed [NUM_W-1:0] TRUNC_BIAS    = (NUM_W'(1) <<< SINE_FRAC_BITS) - NUM_W'(1);
  localparam logic signed [NUM_W-1:0] SAT_MAX       = NUM_W'(32767);
  localparam logic signed [NUM_W-1:0] SAT_MIN       = -NUM_W'(32768);

  typedef enum logic [1:0] {
    FUNC_POINT = 2'd0,
    FUNC_FAST  = 2'd1,
    FUNC_SLOW  = 2'd2
  } func_e;

  typedef enum logic [2:0] {
    KIND_MOVE,
    KIND_END,
    KIND_HOLD,
    KIND_FAST,
    KIND_SLOW
  } kind_e;

  typedef struct packed {
    logic             neg;
    logic [IDX_W-1:0] idx;
  } look_t;

  typedef struct packed {
    kind_e              kind;
    logic signed [15:0] h;
    logic signed [16:0] base;
    logic signed [15:0] desired;
    logic               sin_neg;
    logic               cos_neg;
  } ctrl1_t;

  typedef struct packed {
    kind_e              kind;
    logic signed [16:0] base;
    logic signed [15:0] desired;
  } ctrl2_t;

  // table built at elaboration with a fixed-point taylor series in q60
  localparam logic [63:0] PI_Q60    = 64'h3243F6A8885A308D;
  localparam logic [63:0] SINE_STEP = PI_Q60 / 64'd2000;

  typedef logic [SINE_W-1:0] sine_tab_t [TAB_LAST+1];

  function automatic logic [63:0] mul_q60(input logic [63:0] a, input logic [63:0] b);
    logic [127:0] p;
    p = {64'd0, a} * {64'd0, b};
    return p[123:60];
  endfunction

  // long division by shift and subtract, only used while the table is built
  function automatic logic [63:0] div_u64(input logic [63:0] num, input logic [63:0] den);
    logic [63:0] quo;
    logic [64:0] rem;
    quo = '0;
    rem = '0;
    for (int i = 63; i >= 0; i--) begin
      rem = {rem[63:0], num[i]};
      if (rem >= {1'b0, den}) begin
        rem    = rem - {1'b0, den};
        quo[i] = 1'b1;
      end
    end
    return quo;
  endfunction

  function automatic sine_tab_t build_sine_tab();
    sine_tab_t   tab;
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    logic [63:0] sum;
    logic [63:0] den;
    for (int k = 0; k <= TAB_LAST; k++) begin
      x    = SINE_STEP * 64'(k);
      x2   = mul_q60(x, x);
      term = x;
      sum  = x;
      for (int n = 1; n < 30; n++) begin
        if (term != 64'd0) begin
          den  = 64'(2 * n) * 64'(2 * n + 1);
          term = div_u64(mul_q60(term, x2), den);
          if (n[0]) begin
            sum = sum - term;
          end else begin
            sum = sum + term;
          end
        end
      end
      tab[k] = SINE_W'(sum >> (60 - SINE_FRAC_BITS));
    end
    tab[TAB_LAST] = SINE_W'(1) << SINE_FRAC_BITS;
    return tab;
  endfunction

  localparam sine_tab_t SINE_TAB = build_sine_tab();

  // fold a phase below two turns onto the quarter table
  function automatic look_t fold_phase(input logic [LOOK_W-1:0] p);
    logic [LOOK_W-1:0] q;
    look_t             r;
    q = (p >= LOOK_TURN) ? (p - LOOK_TURN) : p;
    if (q <= LOOK_QUARTER) begin
      r.neg = 1'b0;
      r.idx = IDX_W'(q);
    end else if (q <= LOOK_HALF) begin
      r.neg = 1'b0;
      r.idx = IDX_W'(LOOK_HALF - q);
    end else if (q <= LOOK_3Q) begin
      r.neg = 1'b1;
      r.idx = IDX_W'(q - LOOK_HALF);
    end else begin
      r.neg = 1'b1;
      r.idx = IDX_W'(LOOK_TURN - q);
    end
    return r;
  endfunction

  // divide by 2^frac truncating toward zero, then clamp to 16 bits
  function automatic logic signed [15:0] scale_down(input logic signed [NUM_W-1:0] v);
    logic signed [NUM_W-1:0] t;
    t = v[NUM_W-1] ? (v + TRUNC_BIAS) : v;
    t = t >>> SINE_FRAC_BITS;
    if (t > SAT_MAX) begin
      t = SAT_MAX;
    end else if (t < SAT_MIN) begin
      t = SAT_MIN;
    end
    return t[15:0];
  endfunction

endpackage

@@ design/jtg_sine_rom.sv @@
module jtg_sine_rom import jtg_pkg::*; (
  input  logic              clk_i,
  input  logic              en_i,
  input  logic [IDX_W-1:0]  sin_idx_i,
  input  logic [IDX_W-1:0]  cos_idx_i,
  output logic [SINE_W-1:0] sin_mag_o,
  output logic [SINE_W-1:0] cos_mag_o
);

  logic [SINE_W-1:0] sin_mag_q;
  logic [SINE_W-1:0] cos_mag_q;

  // two read ports, registered data
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sin_mag_q <= SINE_TAB[sin_idx_i];
      cos_mag_q <= SINE_TAB[cos_idx_i];
    end
  end

  assign sin_mag_o = sin_mag_q;
  assign cos_mag_o = cos_mag_q;

endmodule

@@ design/joint_trajectory_generator.sv @@
// channel   | dir | tdata (low bit up)                 | tuser
// s_axis    | in  | desired[15:0]                      | func[1:0]
// m_axis    | out | position, speed, accel (16b each)  | -
//
// one request per cycle sustained while m_axis does not stall; the sine rom is
// read at the accepting edge, the products are registered after it, and the
// scaled and clamped result then goes into the output register that drives m_axis
// the rate is set by the phase/target update loop through the state registers
// and the two-port sine rom (sine and cosine read in the same cycle)
// reset sets the last target to -1, clears the rest of the trajectory state and
// the held setpoints; the table is a constant rom, so there is no clearing pass
// a stall on m_axis fills the bubbles in the stages before s_axis stalls
module joint_trajectory_generator import jtg_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [15:0] s_axis_tdata_i,   // desired[15:0]
  input  logic [1:0]  s_axis_tuser_i,   // func[1:0]
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [47:0] m_axis_tdata_o    // position[15:0], speed[31:16], accel[47:32]
);

  // trajectory state
  logic signed [15:0]  last_target_q, last_target_d;
  logic signed [15:0]  move_start_q, move_start_d;
  logic signed [15:0]  half_span_q, half_span_d;
  logic                move_active_q, move_active_d;
  logic                periodic_q, periodic_d;
  logic [PHASE_W-1:0]  phase_q, phase_d;

  // pipeline valids and stage ready chain
  logic v1_q, v2_q, out_valid_q;
  logic rdy1, rdy2, rdy3;
  logic s_accept;

  assign rdy3     = !out_valid_q || m_axis_tready_i;
  assign rdy2     = !v2_q || rdy3;
  assign rdy1     = !v1_q || rdy2;
  assign s_accept = s_axis_tvalid_i && rdy1;

  assign s_axis_tready_o = rdy1;

  // ---------------- stage 0: state update and table addresses ----------------
  logic signed [15:0]  desired;
  logic signed [16:0]  diff;
  logic signed [16:0]  diff_adj;
  logic signed [15:0]  half_calc;
  logic [PHASE_W-1:0]  phase_t;
  logic [PHASE_W-1:0]  step;
  logic                act_t;
  kind_e               kind0;
  logic signed [16:0]  base0;
  look_t               sin_look;
  look_t               cos_look;

  assign desired  = s_axis_tdata_i;
  assign diff     = {desired[15], desired} - {last_target_q[15], last_target_q};
  // halve toward zero
  assign diff_adj = diff + $signed({16'd0, diff[16]});
  assign half_calc = diff_adj[16:1];

  always_comb begin
    last_target_d = last_target_q;
    move_start_d  = move_start_q;
    half_span_d   = half_span_q;
    move_active_d = move_active_q;
    periodic_d    = periodic_q;
    phase_t       = phase_q;
    act_t         = move_active_q;
    step          = PHASE_STEP_SLOW;
    phase_d       = phase_q;
    kind0         = KIND_HOLD;
    if (s_axis_tuser_i == FUNC_POINT) begin
      periodic_d = 1'b0;
      // new target starts a half-cosine move from the old one
      if (desired != last_target_q) begin
        half_span_d   = half_calc;
        move_start_d  = last_target_q;
        last_target_d = desired;
        phase_t       = '0;
        act_t         = 1'b1;
      end
      move_active_d = act_t;
      phase_d       = phase_t;
      if (act_t) begin
        if (phase_t <= PHASE_HALF) begin
          phase_d = phase_t + PHASE_STEP_POINT;
          kind0   = KIND_MOVE;
        end else begin
          move_active_d = 1'b0;
          kind0         = KIND_END;
        end
      end
    end else begin
      // entering a sine mode from point mode restarts the phase
      if (!periodic_q) begin
        phase_t       = '0;
        move_active_d = 1'b0;
      end
      periodic_d = 1'b1;
      step       = (s_axis_tuser_i == FUNC_FAST) ? PHASE_STEP_FAST : PHASE_STEP_SLOW;
      phase_d    = (phase_t >= PHASE_TURN) ? step : (phase_t + step);
      kind0      = (s_axis_tuser_i == FUNC_FAST) ? KIND_FAST : KIND_SLOW;
    end
  end

  assign base0    = {move_start_d[15], move_start_d} + {half_span_d[15], half_span_d};
  assign sin_look = fold_phase({1'b0, phase_d});
  assign cos_look = fold_phase({1'b0, phase_d} + LOOK_QUARTER);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_target_q <= '1;
      move_start_q  <= '0;
      half_span_q   <= '0;
      move_active_q <= 1'b0;
      periodic_q    <= 1'b0;
      phase_q       <= '0;
    end else if (s_accept) begin
      last_target_q <= last_target_d;
      move_start_q  <= move_start_d;
      half_span_q   <= half_span_d;
      move_active_q <= move_active_d;
      periodic_q    <= periodic_d;
      phase_q       <= phase_d;
    end
  end

  // ---------------- stage 1: sine and cosine read ----------------
  logic [SINE_W-1:0] sin_mag;
  logic [SINE_W-1:0] cos_mag;
  ctrl1_t            ctrl1_q;

  jtg_sine_rom u_rom (
    .clk_i     (clk_i),
    .en_i      (rdy1),
    .sin_idx_i (sin_look.idx),
    .cos_idx_i (cos_look.idx),
    .sin_mag_o (sin_mag),
    .cos_mag_o (cos_mag)
  );

  always_ff @(posedge clk_i) begin
    if (rdy1) begin
      ctrl1_q.kind    <= kind0;
      ctrl1_q.h       <= half_span_d;
      ctrl1_q.base    <= base0;
      ctrl1_q.desired <= desired;
      ctrl1_q.sin_neg <= sin_look.neg;
      ctrl1_q.cos_neg <= cos_look.neg;
    end
  end

  // ---------------- stage 2: amplitude times sine and cosine ----------------
  logic signed [SV_W-1:0]   sin_val;
  logic signed [SV_W-1:0]   cos_val;
  logic signed [15:0]       amp;
  logic signed [PROD_W-1:0] ps_d, pc_d;
  logic signed [PROD_W-1:0] ps_q, pc_q;
  ctrl2_t                   ctrl2_q;

  assign sin_val = ctrl1_q.sin_neg ? -$signed({1'b0, sin_mag}) : $signed({1'b0, sin_mag});
  assign cos_val = ctrl1_q.cos_neg ? -$signed({1'b0, cos_mag}) : $signed({1'b0, cos_mag});

  always_comb begin
    case (ctrl1_q.kind)
      KIND_MOVE: amp = ctrl1_q.h;
      KIND_FAST: amp = AMP_FAST;
      default:   amp = AMP_SLOW;
    endcase
  end

  assign ps_d = PROD_W'(amp) * PROD_W'(sin_val);
  assign pc_d = PROD_W'(amp) * PROD_W'(cos_val);

  always_ff @(posedge clk_i) begin
    if (rdy2) begin
      ps_q            <= ps_d;
      pc_q            <= pc_d;
      ctrl2_q.kind    <= ctrl1_q.kind;
      ctrl2_q.base    <= ctrl1_q.base;
      ctrl2_q.desired <= ctrl1_q.desired;
    end
  end

  // ---------------- stage 3: scale, clamp, output register ----------------
  logic signed [NUM_W-1:0] pos_num, spd_num, acc_num;
  logic signed [NUM_W-1:0] ps_ext, pc_ext;
  logic signed [15:0]      pos_q, spd_q, acc_q;
  logic signed [15:0]      pos_d, spd_d, acc_d;

  assign ps_ext = NUM_W'(ps_q);
  assign pc_ext = NUM_W'(pc_q);

  always_comb begin
    case (ctrl2_q.kind)
      KIND_MOVE: begin
        pos_num = (NUM_W'(ctrl2_q.base) <<< SINE_FRAC_BITS) - pc_ext;
        spd_num = ps_ext;
        acc_num = pc_ext;
      end
      KIND_FAST: begin
        pos_num = ps_ext + OFFS_FAST_NUM;
        spd_num = pc_ext;
        acc_num = -ps_ext;
      end
      default: begin
        pos_num = ps_ext;
        spd_num = pc_ext;
        acc_num = -ps_ext;
      end
    endcase
  end

  always_comb begin
    case (ctrl2_q.kind)
      KIND_END: begin
        pos_d = ctrl2_q.desired;
        spd_d = '0;
        acc_d = '0;
      end
      KIND_HOLD: begin
        // the output register still holds the last result
        pos_d = pos_q;
        spd_d = spd_q;
        acc_d = acc_q;
      end
      default: begin
        pos_d = scale_down(pos_num);
        spd_d = scale_down(spd_num);
        acc_d = scale_down(acc_num);
      end
    endcase
  end

  // output payload doubles as the held setpoints, so it is reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
      spd_q <= '0;
      acc_q <= '0;
    end else if (rdy3 && v2_q) begin
      pos_q <= pos_d;
      spd_q <= spd_d;
      acc_q <= acc_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (rdy1) begin
        v1_q <= s_axis_tvalid_i;
      end
      if (rdy2) begin
        v2_q <= v1_q;
      end
      if (rdy3) begin
        out_valid_q <= v2_q;
      end
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {acc_q, spd_q, pos_q};

  // ---------------- assertions ----------------
  a_phase_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q <= PHASE_MAX)
    else $error("phase beyond its range");

  a_mode_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(move_active_q && periodic_q))
    else $error("point move and sine mode active together");

  a_hold_keeps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rdy3 && v2_q && ctrl2_q.kind == KIND_HOLD) |=> $stable(m_axis_tdata_o))
    else $error("hold request changed the setpoints");

  a_end_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rdy3 && v2_q && ctrl2_q.kind == KIND_END) |=> (m_axis_tdata_o[47:16] == 32'd0))
    else $error("end of move with nonzero speed or accel");

  a_out_from_pipe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid_o) |-> $past(v2_q))
    else $error("result without a request in the last stage");

endmodule

@@ tb/tb_joint_trajectory_generator.sv @@
module tb_joint_trajectory_generator;
  import jtg_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // mode code three is not in the enum, the block treats it as the slow sine
  localparam logic [1:0] FUNC_SLOW_ALIAS = 2'd3;

  // fixed-point scale and quarter-wave size of the sine rom
  localparam int          FRAC      = 15;
  localparam int          ROM_LAST  = 1000;
  localparam longint      UNIT      = 64'sd1 <<< FRAC;
  localparam logic [63:0] PI_FIXED  = 64'h3243F6A8885A308D;

  localparam int RANDOM_GOAL  = 1130;   // random requests after the directed rows
  localparam int LONG_STALL   = 40;     // receiver hold-off, longer than the pipe
  localparam int IDLE_SPAN    = 250;    // requests per idling phase
  localparam int DRAIN_CYCLES = 8;      // idle margin after the last result

  // idling phases: none, sender only, receiver only, both
  localparam int SEND_IDLE_PCT [4] = '{0, 48, 0, 13};
  localparam int RECV_IDLE_PCT [4] = '{0, 0, 48, 13};

  // one result: position in the low bits, accel in the high bits
  typedef struct packed {
    logic signed [15:0] accel;
    logic signed [15:0] speed;
    logic signed [15:0] position;
  } setpoint_t;

  typedef struct packed {
    logic [1:0]         func;
    logic signed [15:0] desired;
    logic               typed;
    setpoint_t          want;
  } stim_row_t;

  localparam int NUM_DIRECTED = 20;

  // directed rows; only the two repeats of the reset target carry a typed result
  localparam stim_row_t DIRECTED [NUM_DIRECTED] = '{
    '{FUNC_POINT,      -16'sd1,     1'b1, '{16'sd0, 16'sd0, 16'sd0}},  // same as reset target
    '{FUNC_POINT,      -16'sd1,     1'b1, '{16'sd0, 16'sd0, 16'sd0}},  // still idle
    '{FUNC_POINT,      16'sh7fff,   1'b0, '0},                         // move to top extreme
    '{FUNC_POINT,      16'sh7fff,   1'b0, '0},
    '{FUNC_POINT,      16'sh8000,   1'b0, '0},                         // retarget mid move
    '{FUNC_POINT,      16'sh8000,   1'b0, '0},
    '{FUNC_POINT,      16'sd0,      1'b0, '0},
    '{FUNC_FAST,       16'sd0,      1'b0, '0},                         // enter fast sine
    '{FUNC_FAST,       16'sh5555,   1'b0, '0},
    '{FUNC_SLOW,       -16'sd1,     1'b0, '0},                         // phase carries on
    '{FUNC_SLOW_ALIAS, 16'sd0,      1'b0, '0},                         // code three as slow
    '{FUNC_SLOW_ALIAS, 16'sh7fff,   1'b0, '0},
    '{FUNC_POINT,      16'sd0,      1'b0, '0},                         // no new target: hold
    '{FUNC_POINT,      16'sd0,      1'b0, '0},
    '{FUNC_POINT,      16'sd1,      1'b0, '0},                         // half span of zero
    '{FUNC_POINT,      -16'sd1,     1'b0, '0},
    '{FUNC_POINT,      16'sh8000,   1'b0, '0},
    '{FUNC_SLOW,       16'sh7fff,   1'b0, '0},
    '{FUNC_FAST,       16'sh8000,   1'b0, '0},
    '{FUNC_POINT,      16'sh00ff,   1'b0, '0}
  };

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata;    // desired[15:0]
  logic [1:0]  s_axis_tuser;    // func[1:0]
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [47:0] m_axis_tdata;    // position[15:0], speed[31:16], accel[47:32]

  joint_trajectory_generator uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid),
    .s_axis_tready_o (s_axis_tready),
    .s_axis_tdata_i  (s_axis_tdata),
    .s_axis_tuser_i  (s_axis_tuser),
    .m_axis_tvalid_o (m_axis_tvalid),
    .m_axis_tready_i (m_axis_tready),
    .m_axis_tdata_o  (m_axis_tdata)
  );

  always #1 clk_i = ~clk_i;

  // quarter-wave sine rom of the trajectory model
  int unsigned quarter_sine [ROM_LAST+1];

  // trajectory model state
  logic signed [15:0] goal_pos;
  logic signed [15:0] origin_pos;
  logic signed [15:0] half_travel;
  logic               move_busy;
  logic               wave_busy;
  logic [11:0]        wave_phase;
  setpoint_t          held;

  setpoint_t pending_setpoints [$];

  int  error_count    = 0;
  int  sent_count     = 0;
  int  checked_count  = 0;
  int  moves_finished = 0;
  int  phase_wraps    = 0;
  int  send_idle_pct  = 0;
  int  recv_idle_pct  = 0;
  bit  stall_request  = 1'b0;

  task automatic flag_error(input string msg);
    error_count++;
    $display("ERROR @%0t: %s", $time, msg);
  endtask

  // q60 product, bits 123:60 of the full result
  function automatic logic [63:0] q60_mul(input logic [63:0] a, input logic [63:0] b);
    logic [127:0] p;
    p = {64'd0, a} * {64'd0, b};
    return p[123:60];
  endfunction

  // taylor series of sin(k*pi/2000) in q60, cut down to the rom scale
  task automatic fill_sine_rom();
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    logic [63:0] acc;
    for (int k = 0; k <= ROM_LAST; k++) begin
      x    = (PI_FIXED / 64'd2000) * 64'(k);
      x2   = q60_mul(x, x);
      term = x;
      acc  = x;
      for (int n = 1; n < 30 && term != 64'd0; n++) begin
        term = q60_mul(term, x2) / (64'(2 * n) * 64'(2 * n + 1));
        if (n % 2 == 1) begin
          acc = acc - term;
        end else begin
          acc = acc + term;
        end
      end
      quarter_sine[k] = 32'(acc >> (60 - FRAC));
    end
    quarter_sine[ROM_LAST] = 32'd1 << FRAC;
  endtask

  // signed sine of a phase in 4000ths of a turn
  function automatic longint sine_of(input int unsigned p);
    int unsigned q;
    q = p % 4000;
    if (q <= 1000) return longint'(quarter_sine[q]);
    if (q <= 2000) return longint'(quarter_sine[2000 - q]);
    if (q <= 3000) return -longint'(quarter_sine[q - 2000]);
    return -longint'(quarter_sine[4000 - q]);
  endfunction

  // divide by the rom scale toward zero, clamp to 16 bits
  function automatic logic signed [15:0] to_setpoint(input longint num);
    longint v;
    v = (num >= 0) ? (num >>> FRAC) : -((-num) >>> FRAC);
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return v[15:0];
  endfunction

  task automatic reset_trajectory();
    goal_pos    = -16'sd1;
    origin_pos  = '0;
    half_travel = '0;
    move_busy   = 1'b0;
    wave_busy   = 1'b0;
    wave_phase  = '0;
    held        = '0;
  endtask

  // advance the trajectory model by one tick
  task automatic next_setpoint(input logic [1:0] f, input logic signed [15:0] d,
                               output setpoint_t r);
    longint      s;
    longint      c;
    longint      h;
    longint      amp;
    longint      offs;
    int unsigned step;
    if (f == FUNC_POINT) begin
      wave_busy = 1'b0;
      if (d != goal_pos) begin
        // new target: half-cosine move from the previous one
        half_travel = 16'((int'(d) - int'(goal_pos)) / 2);
        origin_pos  = goal_pos;
        goal_pos    = d;
        wave_phase  = '0;
        move_busy   = 1'b1;
      end
      if (move_busy) begin
        if (wave_phase <= 12'd2000) begin
          wave_phase    = wave_phase + 12'd2;
          h             = longint'(half_travel);
          s             = sine_of(wave_phase);
          c             = sine_of(wave_phase + 1000);
          held.position = to_setpoint((longint'(origin_pos) + h) * UNIT - h * c);
          held.speed    = to_setpoint(h * s);
          held.accel    = to_setpoint(h * c);
        end else begin
          // past half a turn: settle on the target
          move_busy     = 1'b0;
          moves_finished++;
          held.position = d;
          held.speed    = '0;
          held.accel    = '0;
        end
      end
    end else begin
      step = (f == FUNC_FAST) ? 4 : 1;
      amp  = (f == FUNC_FAST) ? 4096 : 8192;
      offs = (f == FUNC_FAST) ? 4096 : 0;
      if (!wave_busy) begin
        wave_busy  = 1'b1;
        move_busy  = 1'b0;
        wave_phase = '0;
      end
      if (wave_phase >= 12'd4000) begin
        wave_phase = 12'(step);
        phase_wraps++;
      end else begin
        wave_phase = wave_phase + 12'(step);
      end
      s             = sine_of(wave_phase);
      c             = sine_of(wave_phase + 1000);
      held.position = to_setpoint(amp * s + offs * UNIT);
      held.speed    = to_setpoint(amp * c);
      held.accel    = to_setpoint(-amp * s);
    end
    r = held;
  endtask

  // random target: extremes, near zero, or anything
  function automatic logic signed [15:0] pick_target();
    case ($urandom_range(3))
      0:       return 16'sh7fff;
      1:       return 16'sh8000;
      2:       return 16'($urandom_range(64)) - 16'sd32;
      default: return 16'($urandom);
    endcase
  endfunction

  // offer one request, called and returning on a rising edge
  task automatic offer(input logic [1:0] f, input logic signed [15:0] d,
                       input logic typed, input setpoint_t want);
    setpoint_t predicted;
    send_idle_pct = SEND_IDLE_PCT[(sent_count / IDLE_SPAN) % 4];
    recv_idle_pct = RECV_IDLE_PCT[(sent_count / IDLE_SPAN) % 4];
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= d;
    s_axis_tuser  <= f;
    // values at the falling edge hold for the next rising edge
    @(negedge clk_i);
    while (!s_axis_tready) @(negedge clk_i);
    next_setpoint(f, d, predicted);
    pending_setpoints.push_back(typed ? want : predicted);
    sent_count++;
    @(posedge clk_i);
  endtask

  // stop offering until every expected result is back
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (pending_setpoints.size() != 0);
  endtask

  // receiver: random stalls, and one long hold-off on request
  initial begin
    int stall_count;
    m_axis_tready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (stall_request) begin
        m_axis_tready <= 1'b0;
        for (stall_count = 0; stall_count < LONG_STALL; stall_count++) @(posedge clk_i);
        stall_request = 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // result check against the oldest expectation
  always @(negedge clk_i) begin
    setpoint_t got;
    setpoint_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata;
      if (pending_setpoints.size() == 0) begin
        flag_error($sformatf("unexpected result %h", m_axis_tdata));
      end else begin
        want = pending_setpoints.pop_front();
        checked_count++;
        if (got.position !== want.position)
          flag_error($sformatf("result %0d position %0d, want %0d",
                               checked_count, got.position, want.position));
        if (got.speed !== want.speed)
          flag_error($sformatf("result %0d speed %0d, want %0d",
                               checked_count, got.speed, want.speed));
        if (got.accel !== want.accel)
          flag_error($sformatf("result %0d accel %0d, want %0d",
                               checked_count, got.accel, want.accel));
      end
    end
  end

  // hard stop if the run hangs
  initial begin
    #1_000_000;
    $display("joint_trajectory_generator regression: fail");
    $finish;
  end

  initial begin
    int                 nsub;
    int                 len;
    logic [1:0]         f;
    logic signed [15:0] target;
    logic signed [15:0] d;
    bit                 long_move_done;
    long_move_done = 1'b0;

    rst_ni        <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= '0;
    fill_sine_rom();
    reset_trajectory();
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed rows
    for (int i = 0; i < NUM_DIRECTED; i++) begin
      offer(DIRECTED[i].func, DIRECTED[i].desired, DIRECTED[i].typed, DIRECTED[i].want);
    end

    // random part, built from blocks of well-formed runs and some noise
    while (sent_count - NUM_DIRECTED < RANDOM_GOAL) begin
      if (!long_move_done) begin
        // one move carried through to the end and then held
        target = pick_target();
        if (target == goal_pos) target = ~target;
        for (int i = 0; i < 1010; i++) begin
          // long receiver hold-off while the sender keeps offering
          if (i == 500) stall_request = 1'b1;
          offer(FUNC_POINT, target, 1'b0, '0);
        end
        long_move_done = 1'b1;
        // sender pause until the pipe is empty
        drain();
      end else begin
        case ($urandom_range(9))
          0, 1, 2, 3: begin
            // point run, mostly steady target with a rare retarget
            target = ($urandom_range(2) == 0) ? goal_pos : pick_target();
            len    = $urandom_range(1, 40);
            for (int i = 0; i < len; i++) begin
              d = ($urandom_range(15) == 0) ? 16'($urandom) : target;
              offer(FUNC_POINT, d, 1'b0, '0);
            end
          end
          4, 5, 6, 7, 8: begin
            // chain of sine runs, phase carried across mode switches
            nsub = $urandom_range(1, 3);
            for (int k = 0; k < nsub; k++) begin
              f   = 2'($urandom_range(1, 3));
              len = $urandom_range(1, 40);
              for (int i = 0; i < len; i++) offer(f, 16'($urandom), 1'b0, '0);
            end
          end
          default: begin
            // noise: any mode, any target
            len = $urandom_range(1, 20);
            for (int i = 0; i < len; i++) begin
              offer(2'($urandom_range(3)), 16'($urandom), 1'b0, '0);
            end
          end
        endcase
      end
    end

    drain();
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("sent %0d requests (%0d directed), checked %0d results",
             sent_count, NUM_DIRECTED, checked_count);
    $display("covered %0d finished moves and %0d sine phase wraps, %0d errors",
             moves_finished, phase_wraps, error_count);
    if (error_count == 0 && pending_setpoints.size() == 0) begin
      $display("joint_trajectory_generator regression: pass");
    end else begin
      $display("joint_trajectory_generator regression: fail");
    end
    $finish;
  end

endmodule

@@ sim.f @@
design/jtg_pkg.sv
design/jtg_sine_rom.sv
design/joint_trajectory_generator.sv
tb/tb_joint_trajectory_generator.sv
